@@ src/scrseq_pkg.sv @@
// Shared types and constants for the scripted input sequencer.
package scrseq_pkg;

  localparam logic [2:0] KIND_CLEAR  = 3'd0;
  localparam logic [2:0] KIND_APPEND = 3'd1;
  localparam logic [2:0] KIND_START  = 3'd2;
  localparam logic [2:0] KIND_TICK   = 3'd3;
  localparam logic [2:0] KIND_READ   = 3'd4;

  localparam logic [3:0] OP_WAIT     = 4'd0;
  localparam logic [3:0] OP_HOLD     = 4'd1;
  localparam logic [3:0] OP_UNHOLD   = 4'd2;
  localparam logic [3:0] OP_TAP      = 4'd3;
  localparam logic [3:0] OP_ASSERT8  = 4'd4;
  localparam logic [3:0] OP_POLL8    = 4'd5;
  localparam logic [3:0] OP_ASSERT16 = 4'd6;
  localparam logic [3:0] OP_POLL16   = 4'd7;
  localparam logic [3:0] OP_EXIT     = 4'd9;

  localparam logic [7:0] ALL_BUTTONS = 8'hFF;

  typedef struct packed {
    logic [7:0]  buttons;
    logic [3:0]  code;
    logic [31:0] arg;
    logic [31:0] value;
  } prog_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TIMERS,
    ST_WAITCHK,
    ST_RUN,
    ST_FETCH,
    ST_EXEC,
    ST_DONE
  } seq_state_t;

endpackage

@@ src/scrseq_store.sv @@
// Program store: one write port for appends, one registered read port.
module scrseq_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  scrseq_pkg::prog_word_t  wdata,
  input  logic [AW-1:0]           raddr,
  output scrseq_pkg::prog_word_t  rdata
);
  import scrseq_pkg::*;

  prog_word_t mem [DEPTH];
  prog_word_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/scripted_input_sequencer_top.sv @@
// Top level of the scripted input sequencer: control sequencer and state.
// Latency: clear, append, start and ignored words raise their result strobe in
// the cycle after acceptance. A tick runs a timer scan over the TIMER_SLOTS slots, a
// wait check, then per op a check, a store read and an execute (plus a recheck
// after a wait op), a final check when the program runs out, and the strobe.
// Throughput is one word at a time; busy stays high until the strobe. Reset
// (synchronous, rst_n low) clears all state but the read operands and the store.
module scripted_input_sequencer_top #(
  parameter int PROGRAM_DEPTH = 4096,
  parameter int TIMER_SLOTS   = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_kind,
  input  logic [3:0]  in_op_code,
  input  logic [31:0] in_op_arg,
  input  logic [31:0] in_op_value,
  input  logic [7:0]  in_op_buttons,
  input  logic [63:0] in_frame,
  input  logic [15:0] in_read_data,
  output logic        out_valid,
  output logic [7:0]  out_held_mask,
  output logic        out_read_request,
  output logic [31:0] out_read_address,
  output logic        out_read_wide,
  output logic        out_exit_pending,
  output logic [31:0] out_exit_code,
  output logic        out_assert_failed,
  output logic [11:0] out_failed_index,
  output logic        out_running,
  output logic        out_load_rejected
);
  import scrseq_pkg::*;

  localparam int AW = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;
  localparam int LW = $clog2(PROGRAM_DEPTH + 1);
  localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  seq_state_t state_r, state_nxt;

  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] pc_r, pc_nxt;
  logic          active_r, active_nxt;
  logic [63:0]   wait_until_r, wait_until_nxt;
  logic [7:0]    held_r, held_nxt;
  logic [7:0]    tmask_r [TIMER_SLOTS];
  logic [7:0]    tmask_nxt [TIMER_SLOTS];
  logic [63:0]   trel_r [TIMER_SLOTS];
  logic [63:0]   trel_nxt [TIMER_SLOTS];
  logic          exit_r, exit_nxt;
  logic [31:0]   exit_val_r, exit_val_nxt;
  logic          await_r, await_nxt;
  logic [63:0]   frame_r, frame_nxt;
  logic          halted_r, halted_nxt;
  logic          rej_r, rej_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [31:0]   raddr_r, raddr_nxt;
  logic [3:0]    mcode_r, mcode_nxt;
  logic [15:0]   mval_r, mval_nxt;

  logic          accept;
  logic          st_we;
  prog_word_t    st_wdata;
  prog_word_t    op;
  logic [63:0]   sum;
  logic          free_found;
  logic [SW-1:0] free_slot;
  logic          wide_cmp;
  logic          rd_match;
  logic [LW+11:0] pc_ext;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // Appends are the only writes; the read port follows the program counter.
  assign st_we    = accept && (in_kind == KIND_APPEND) && (len_r != LW'(PROGRAM_DEPTH));
  assign st_wdata = '{buttons: in_op_buttons, code: in_op_code,
                      arg: in_op_arg, value: in_op_value};

  scrseq_store #(.DEPTH(PROGRAM_DEPTH), .AW(AW)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (len_r[AW-1:0]),
    .wdata (st_wdata),
    .raddr (pc_r[AW-1:0]),
    .rdata (op)
  );

  // The single shared adder forms wait deadlines and press release frames.
  assign sum = frame_r + {32'd0, (op.code == OP_WAIT) ? op.arg : op.value};

  // First empty timer slot for a press.
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      if (!free_found && tmask_r[i] == 8'd0) begin
        free_found = 1'b1;
        free_slot  = SW'(i);
      end
    end
  end

  // A byte check compares the low eight bits only.
  assign wide_cmp = (mcode_r == OP_ASSERT16) || (mcode_r == OP_POLL16);
  assign rd_match = wide_cmp ? (in_read_data == mval_r)
                             : (in_read_data[7:0] == mval_r[7:0]);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_DONE;
          if (in_kind == KIND_TICK && active_r && !halted_r && !await_r) begin
            state_nxt = ST_TIMERS;
          end else if (in_kind == KIND_READ && await_r && rd_match) begin
            state_nxt = ST_RUN;
          end
        end
      end
      ST_TIMERS: begin
        if (slot_r == SW'(TIMER_SLOTS - 1)) begin
          state_nxt = ST_WAITCHK;
        end
      end
      ST_WAITCHK: state_nxt = (frame_r < wait_until_r) ? ST_DONE : ST_RUN;
      ST_RUN:     state_nxt = (pc_r < len_r) ? ST_FETCH : ST_DONE;
      ST_FETCH:   state_nxt = ST_EXEC;
      ST_EXEC: begin
        unique case (op.code) inside
          OP_WAIT:                     state_nxt = ST_WAITCHK;
          OP_ASSERT8, OP_POLL8,
          OP_ASSERT16, OP_POLL16,
          OP_EXIT:                     state_nxt = ST_DONE;
          default:                     state_nxt = ST_RUN;
        endcase
      end
      ST_DONE:    state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Register updates.
  always_comb begin
    len_nxt        = len_r;
    pc_nxt         = pc_r;
    active_nxt     = active_r;
    wait_until_nxt = wait_until_r;
    held_nxt       = held_r;
    tmask_nxt      = tmask_r;
    trel_nxt       = trel_r;
    exit_nxt       = exit_r;
    exit_val_nxt   = exit_val_r;
    await_nxt      = await_r;
    frame_nxt      = frame_r;
    halted_nxt     = halted_r;
    rej_nxt        = rej_r;
    slot_nxt       = slot_r;
    raddr_nxt      = raddr_r;
    mcode_nxt      = mcode_r;
    mval_nxt       = mval_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          rej_nxt  = 1'b0;
          slot_nxt = '0;
          case (in_kind)
            KIND_CLEAR: begin
              len_nxt    = '0;
              pc_nxt     = '0;
              active_nxt = 1'b0;
              held_nxt   = 8'd0;
              for (int i = 0; i < TIMER_SLOTS; i++) begin
                tmask_nxt[i] = 8'd0;
                trel_nxt[i]  = 64'd0;
              end
              exit_nxt   = 1'b0;
              await_nxt  = 1'b0;
              halted_nxt = 1'b0;
            end
            KIND_APPEND: begin
              if (len_r == LW'(PROGRAM_DEPTH)) begin
                rej_nxt = 1'b1;
              end else begin
                len_nxt = len_r + LW'(1);
              end
            end
            KIND_START: active_nxt = 1'b1;
            KIND_TICK: begin
              if (active_r && !halted_r && !await_r) begin
                frame_nxt = in_frame;
              end
            end
            KIND_READ: begin
              if (await_r) begin
                await_nxt = 1'b0;
                if (rd_match) begin
                  pc_nxt = pc_r + LW'(1);
                end else if (mcode_r == OP_ASSERT8 || mcode_r == OP_ASSERT16) begin
                  halted_nxt = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_TIMERS: begin
        if (tmask_r[slot_r] != 8'd0 && frame_r >= trel_r[slot_r]) begin
          held_nxt = held_r & ~tmask_r[slot_r];
          tmask_nxt[slot_r] = 8'd0;
        end
        slot_nxt = slot_r + SW'(1);
      end
      ST_EXEC: begin
        case (op.code) inside
          OP_WAIT: begin
            wait_until_nxt = sum;
            pc_nxt         = pc_r + LW'(1);
          end
          OP_HOLD: begin
            held_nxt = held_r | op.buttons;
            pc_nxt   = pc_r + LW'(1);
          end
          OP_UNHOLD: begin
            held_nxt = (op.buttons == ALL_BUTTONS) ? 8'd0 : (held_r & ~op.buttons);
            pc_nxt   = pc_r + LW'(1);
          end
          OP_TAP: begin
            held_nxt = held_r | op.buttons;
            if (free_found) begin
              tmask_nxt[free_slot] = op.buttons;
              trel_nxt[free_slot]  = sum;
            end
            pc_nxt = pc_r + LW'(1);
          end
          OP_ASSERT8, OP_POLL8, OP_ASSERT16, OP_POLL16: begin
            await_nxt = 1'b1;
            raddr_nxt = op.arg;
            mcode_nxt = op.code;
            mval_nxt  = op.value[15:0];
          end
          OP_EXIT: begin
            exit_nxt     = 1'b1;
            exit_val_nxt = op.arg;
            pc_nxt       = pc_r + LW'(1);
          end
          default: pc_nxt = pc_r + LW'(1);
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      len_r        <= '0;
      pc_r         <= '0;
      active_r     <= 1'b0;
      wait_until_r <= 64'd0;
      held_r       <= 8'd0;
      for (int i = 0; i < TIMER_SLOTS; i++) begin
        tmask_r[i] <= 8'd0;
        trel_r[i]  <= 64'd0;
      end
      exit_r       <= 1'b0;
      exit_val_r   <= 32'd0;
      await_r      <= 1'b0;
      frame_r      <= 64'd0;
      halted_r     <= 1'b0;
      rej_r        <= 1'b0;
      slot_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      len_r        <= len_nxt;
      pc_r         <= pc_nxt;
      active_r     <= active_nxt;
      wait_until_r <= wait_until_nxt;
      held_r       <= held_nxt;
      tmask_r      <= tmask_nxt;
      trel_r       <= trel_nxt;
      exit_r       <= exit_nxt;
      exit_val_r   <= exit_val_nxt;
      await_r      <= await_nxt;
      frame_r      <= frame_nxt;
      halted_r     <= halted_nxt;
      rej_r        <= rej_nxt;
      slot_r       <= slot_nxt;
    end
  end

  // The pending read's address and comparison operands need no reset.
  always_ff @(posedge clk) begin
    raddr_r <= raddr_nxt;
    mcode_r <= mcode_nxt;
    mval_r  <= mval_nxt;
  end

  assign pc_ext = {12'd0, pc_r};

  // The result word is shown for exactly one cycle in the done state.
  assign out_valid         = (state_r == ST_DONE);
  assign out_held_mask     = held_r;
  assign out_read_request  = await_r;
  assign out_read_address  = await_r ? raddr_r : 32'd0;
  assign out_read_wide     = await_r && wide_cmp;
  assign out_exit_pending  = exit_r;
  assign out_exit_code     = exit_val_r;
  assign out_assert_failed = halted_r;
  assign out_failed_index  = halted_r ? pc_ext[11:0] : 12'd0;
  assign out_running       = active_r && !halted_r;
  assign out_load_rejected = rej_r;

endmodule

@@ src/scrseq_checker.sv @@
// Port-level checker for the scripted input sequencer, bound to the top level.
module scrseq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic        out_read_request,
  input logic [31:0] out_read_address,
  input logic        out_assert_failed,
  input logic        out_running
);

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result strobe while not busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted word did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy) else $error("strobe held or busy after result");

  a_halt_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_assert_failed |-> !out_running) else $error("running while halted");

  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_read_request |-> out_read_address == 32'd0)
    else $error("read address shown without a request");

endmodule

bind scripted_input_sequencer_top scrseq_checker u_scrseq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_read_request  (out_read_request),
  .out_read_address  (out_read_address),
  .out_assert_failed (out_assert_failed),
  .out_running       (out_running)
);

@@ test/testbench.sv @@
// Self-checking testbench for the scripted input sequencer top level.
`timescale 1ns / 100ps

module testbench;
  import scrseq_pkg::*;

  localparam int DEPTH = 4096;
  localparam int SLOTS = 4;
  localparam logic [3:0] OP_SHOT  = 4'd8;
  localparam logic [3:0] OP_SPARE = 4'd15;
  localparam logic [2:0] KIND_SPARE = 3'd7;

  // One input word as it goes onto the in_ ports.
  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  code;
    logic [31:0] arg;
    logic [31:0] value;
    logic [7:0]  buttons;
    logic [63:0] frame;
    logic [15:0] rdata;
  } word_t;

  // One result word as it appears on the out_ ports.
  typedef struct packed {
    logic [7:0]  held;
    logic        rd_req;
    logic [31:0] rd_addr;
    logic        rd_wide;
    logic        exit_pend;
    logic [31:0] exit_code;
    logic        failed;
    logic [11:0] fail_idx;
    logic        running;
    logic        rejected;
  } status_t;

  // A directed row: the word, plus a hand-written result where one is given.
  typedef struct packed {
    word_t   w;
    logic    typed;
    status_t res;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_kind;
  logic [3:0]  in_op_code;
  logic [31:0] in_op_arg;
  logic [31:0] in_op_value;
  logic [7:0]  in_op_buttons;
  logic [63:0] in_frame;
  logic [15:0] in_read_data;
  logic        out_valid;
  status_t     seen;

  scripted_input_sequencer_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_op_code        (in_op_code),
    .in_op_arg         (in_op_arg),
    .in_op_value       (in_op_value),
    .in_op_buttons     (in_op_buttons),
    .in_frame          (in_frame),
    .in_read_data      (in_read_data),
    .out_valid         (out_valid),
    .out_held_mask     (seen.held),
    .out_read_request  (seen.rd_req),
    .out_read_address  (seen.rd_addr),
    .out_read_wide     (seen.rd_wide),
    .out_exit_pending  (seen.exit_pend),
    .out_exit_code     (seen.exit_code),
    .out_assert_failed (seen.failed),
    .out_failed_index  (seen.fail_idx),
    .out_running       (seen.running),
    .out_load_rejected (seen.rejected)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Shadow copy of the sequencer: program store, counters, timers and flags.
  logic [3:0]  prog_code [DEPTH];
  logic [7:0]  prog_btn [DEPTH];
  logic [31:0] prog_arg [DEPTH];
  logic [31:0] prog_val [DEPTH];
  int          prog_len;
  int          pc;
  logic        active;
  logic [63:0] wait_until;
  logic [7:0]  held;
  logic [7:0]  slot_mask [SLOTS];
  logic [63:0] slot_due [SLOTS];
  logic        exit_flag;
  logic [31:0] exit_val;
  logic        read_pending;
  logic [63:0] held_frame;
  logic        halted;

  status_t status_queue[$];
  int      mismatches;
  int      words_sent;
  int      results_seen;
  int      fails_seen;
  int      rejects_seen;
  int      gap_pct;
  logic [63:0] now_frame;

  task automatic shadow_reset();
    prog_len = 0;
    pc = 0;
    active = 1'b0;
    wait_until = '0;
    held = '0;
    exit_flag = 1'b0;
    exit_val = '0;
    read_pending = 1'b0;
    held_frame = '0;
    halted = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_mask[i] = '0;
      slot_due[i] = '0;
    end
  endtask

  // Executes ops from the counter until one blocks or exits, or the program ends.
  task automatic execute_ops(input logic [63:0] f);
    logic [7:0]  b;
    logic [31:0] a;
    logic [31:0] v;
    while (pc < prog_len) begin
      b = prog_btn[pc];
      a = prog_arg[pc];
      v = prog_val[pc];
      case (prog_code[pc])
        OP_WAIT: begin
          wait_until = f + 64'(a);
          pc++;
          if (f < wait_until) return;
        end
        OP_HOLD: begin
          held |= b;
          pc++;
        end
        OP_UNHOLD: begin
          held = (b == ALL_BUTTONS) ? 8'h00 : (held & ~b);
          pc++;
        end
        OP_TAP: begin
          held |= b;
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_mask[i] == 8'h00) begin
              slot_mask[i] = b;
              slot_due[i] = f + 64'(v);
              break;
            end
          end
          pc++;
        end
        OP_ASSERT8, OP_POLL8, OP_ASSERT16, OP_POLL16: begin
          read_pending = 1'b1;
          held_frame = f;
          return;
        end
        OP_EXIT: begin
          exit_flag = 1'b1;
          exit_val = a;
          pc++;
          return;
        end
        default: pc++;
      endcase
    end
  endtask

  function automatic logic is_wide(input logic [3:0] c);
    return (c == OP_ASSERT16) || (c == OP_POLL16);
  endfunction

  // Applies one word to the shadow state and returns the status it should produce.
  task automatic predict_status(input word_t w, output status_t s);
    logic        rej;
    logic [15:0] keep;
    rej = 1'b0;
    case (w.kind)
      KIND_CLEAR: begin
        prog_len = 0;
        pc = 0;
        active = 1'b0;
        held = '0;
        exit_flag = 1'b0;
        read_pending = 1'b0;
        halted = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
          slot_mask[i] = '0;
          slot_due[i] = '0;
        end
      end
      KIND_APPEND: begin
        if (prog_len >= DEPTH) begin
          rej = 1'b1;
        end else begin
          prog_code[prog_len] = w.code;
          prog_btn[prog_len] = w.buttons;
          prog_arg[prog_len] = w.arg;
          prog_val[prog_len] = w.value;
          prog_len++;
        end
      end
      KIND_START: active = 1'b1;
      KIND_TICK: begin
        if (active && !halted && !read_pending) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_mask[i] != 8'h00 && w.frame >= slot_due[i]) begin
              held &= ~slot_mask[i];
              slot_mask[i] = '0;
            end
          end
          if (w.frame >= wait_until) execute_ops(w.frame);
        end
      end
      KIND_READ: begin
        if (read_pending) begin
          read_pending = 1'b0;
          if (pc < prog_len) begin
            keep = is_wide(prog_code[pc]) ? 16'hFFFF : 16'h00FF;
            if (((w.rdata & keep) != (prog_val[pc][15:0] & keep))) begin
              if (prog_code[pc] == OP_ASSERT8 || prog_code[pc] == OP_ASSERT16)
                halted = 1'b1;
            end else begin
              pc++;
              execute_ops(held_frame);
            end
          end
        end
      end
      default: ;
    endcase
    s = '0;
    s.held = held;
    s.rd_req = read_pending;
    if (read_pending && pc < DEPTH) begin
      s.rd_addr = prog_arg[pc];
      s.rd_wide = is_wide(prog_code[pc]);
    end
    s.exit_pend = exit_flag;
    s.exit_code = exit_val;
    s.failed = halted;
    s.fail_idx = halted ? 12'(pc) : 12'h000;
    s.running = active && !halted;
    s.rejected = rej;
  endtask

  // Sends one word after a random idle gap. A typed result, when given, replaces
  // the predicted one as the expectation, but the shadow state still advances.
  task automatic send_word(input word_t w, input logic typed, input status_t typed_res);
    status_t s;
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    predict_status(w, s);
    status_queue.push_back(typed ? typed_res : s);
    start         <= 1'b1;
    in_kind       <= w.kind;
    in_op_code    <= w.code;
    in_op_arg     <= w.arg;
    in_op_value   <= w.value;
    in_op_buttons <= w.buttons;
    in_frame      <= w.frame;
    in_read_data  <= w.rdata;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
  endtask

  task automatic send(input word_t w);
    send_word(w, 1'b0, '0);
  endtask

  function automatic word_t make_word(input logic [2:0] k);
    word_t w;
    w = '0;
    w.kind = k;
    return w;
  endfunction

  // Builds a random op, mostly the ten real ones, with small waits and durations.
  function automatic word_t random_op();
    word_t w;
    w = make_word(KIND_APPEND);
    w.code = ($urandom_range(15) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(9));
    case ($urandom_range(7))
      0: w.buttons = ALL_BUTTONS;
      1: w.buttons = 8'h00;
      default: w.buttons = 8'($urandom);
    endcase
    w.arg = ($urandom_range(19) == 0) ? $urandom : 32'($urandom_range(3));
    if (w.code != OP_WAIT) w.arg = $urandom;
    w.value = ($urandom_range(15) == 0) ? $urandom : 32'($urandom_range(6));
    if (w.code >= OP_ASSERT8 && w.code <= OP_POLL16) w.value = $urandom;
    return w;
  endfunction

  // A tick at the running frame count, with an occasional jump anywhere.
  task automatic send_tick();
    word_t w;
    if ($urandom_range(39) == 0) now_frame = {$urandom, $urandom};
    else now_frame += 64'($urandom_range(3));
    w = make_word(KIND_TICK);
    w.frame = now_frame;
    send(w);
  endtask

  // Answers a pending read, usually with the value the op expects.
  task automatic send_read();
    word_t w;
    w = make_word(KIND_READ);
    w.rdata = 16'($urandom);
    if (read_pending && pc < prog_len && $urandom_range(3) != 0) begin
      if (is_wide(prog_code[pc])) w.rdata = prog_val[pc][15:0];
      else w.rdata[7:0] = prog_val[pc][7:0];
    end
    send(w);
  endtask

  // Results are taken at the edge that ends their strobe cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (seen.failed) fails_seen++;
      if (seen.rejected) rejects_seen++;
      if (status_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word: %p", seen);
      end else begin
        status_t want;
        want = status_queue.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, seen);
        end
      end
    end
  end

  // Guard against a hung handshake.
  initial begin
    #10ms;
    $display("Timeout with %0d result words outstanding", status_queue.size());
    $display("Some tests failed");
    $finish;
  end

  row_t    rows[25];
  word_t   w;
  status_t z;
  int      n_ops;
  int      ticks;
  logic    paused;

  initial begin
    start = 1'b0;
    in_kind = '0;
    in_op_code = '0;
    in_op_arg = '0;
    in_op_value = '0;
    in_op_buttons = '0;
    in_frame = '0;
    in_read_data = '0;
    rst_n = 1'b0;
    mismatches = 0;
    words_sent = 0;
    results_seen = 0;
    fails_seen = 0;
    rejects_seen = 0;
    gap_pct = 16;
    now_frame = '0;
    paused = 1'b0;
    shadow_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. A few rows carry a hand-written result; the rest use the
    // shadow model. The script covers every op kind but POLL8, a byte assert
    // passing with a junk upper byte, a poll that misses and is retried, timer
    // expiry, a blocking wait, release-all, a no-op code, screenshot, an exit
    // with an all-ones code and a 16-bit assert failing at the top frame number.
    z = '0;
    foreach (rows[i]) rows[i] = '0;
    rows[0].w = make_word(KIND_TICK);     rows[0].typed = 1'b1;  rows[0].res = z;
    rows[1].w = make_word(KIND_READ);     rows[1].w.rdata = 16'hFFFF;
    rows[1].typed = 1'b1;  rows[1].res = z;
    rows[2].w = make_word(KIND_SPARE);    rows[2].typed = 1'b1;  rows[2].res = z;
    rows[3].w = make_word(KIND_APPEND);   rows[3].w.code = OP_HOLD;
    rows[3].w.buttons = 8'h81;            rows[3].typed = 1'b1;  rows[3].res = z;
    rows[4].w = make_word(KIND_APPEND);   rows[4].w.code = OP_TAP;
    rows[4].w.buttons = 8'h02;            rows[4].w.value = 32'd2;
    rows[5].w = make_word(KIND_APPEND);   rows[5].w.code = OP_ASSERT8;
    rows[5].w.arg = 32'hFFFF_FFFF;        rows[5].w.value = 32'h1234_56AB;
    rows[6].w = make_word(KIND_APPEND);   rows[6].w.code = OP_POLL16;
    rows[6].w.arg = 32'h0000_1000;        rows[6].w.value = 32'h0000_BEEF;
    rows[7].w = make_word(KIND_APPEND);   rows[7].w.code = OP_WAIT;
    rows[7].w.arg = 32'd3;
    rows[8].w = make_word(KIND_APPEND);   rows[8].w.code = OP_UNHOLD;
    rows[8].w.buttons = ALL_BUTTONS;
    rows[9].w = make_word(KIND_APPEND);   rows[9].w.code = OP_SPARE;
    rows[10].w = make_word(KIND_APPEND);  rows[10].w.code = OP_SHOT;
    rows[11].w = make_word(KIND_APPEND);  rows[11].w.code = OP_EXIT;
    rows[11].w.arg = 32'hFFFF_FFFF;
    rows[12].w = make_word(KIND_START);   rows[12].typed = 1'b1;
    rows[12].res = z;                     rows[12].res.running = 1'b1;
    rows[13].w = make_word(KIND_TICK);    rows[13].w.frame = 64'd10;
    rows[14].w = make_word(KIND_READ);    rows[14].w.rdata = 16'hFFAB;
    rows[15].w = make_word(KIND_READ);    rows[15].w.rdata = 16'h0000;
    rows[16].w = make_word(KIND_TICK);    rows[16].w.frame = 64'd13;
    rows[17].w = make_word(KIND_READ);    rows[17].w.rdata = 16'hBEEF;
    rows[18].w = make_word(KIND_TICK);    rows[18].w.frame = 64'd15;
    rows[19].w = make_word(KIND_TICK);    rows[19].w.frame = 64'd16;
    rows[20].w = make_word(KIND_CLEAR);
    rows[21].w = make_word(KIND_APPEND);  rows[21].w.code = OP_ASSERT16;
    rows[21].w.value = 32'h0000_FFFF;
    rows[22].w = make_word(KIND_START);
    rows[23].w = make_word(KIND_TICK);    rows[23].w.frame = 64'hFFFF_FFFF_FFFF_FFFF;
    rows[24].w = make_word(KIND_READ);    rows[24].typed = 1'b1;
    rows[24].res = z;                     rows[24].res.exit_code = 32'hFFFF_FFFF;
    rows[24].res.failed = 1'b1;
    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].res);

    // Random part: mostly whole scripts (clear, appends, start, ticks and read
    // answers), sometimes appended to a running script, with stray words mixed in.
    while (words_sent < 1850) begin
      if (words_sent < 640) gap_pct = 16;
      else if (words_sent < 1260) gap_pct = 57;
      else gap_pct = 0;
      // Hold the input side until every outstanding result word is back.
      if (!paused && words_sent > 900) begin
        paused = 1'b1;
        start <= 1'b0;
        @(posedge clk);
        while (status_queue.size() != 0) @(posedge clk);
      end
      if ($urandom_range(99) < 15) begin
        w.kind = 3'($urandom_range(7));
        w.code = 4'($urandom);
        w.arg = $urandom;
        w.value = $urandom;
        w.buttons = 8'($urandom);
        w.frame = {$urandom, $urandom};
        w.rdata = 16'($urandom);
        send(w);
      end else begin
        if ($urandom_range(4) != 0) send(make_word(KIND_CLEAR));
        n_ops = $urandom_range(1, 10);
        for (int i = 0; i < n_ops; i++) send(random_op());
        send(make_word(KIND_START));
        ticks = 0;
        while (ticks < 30 && !halted && (pc < prog_len || read_pending)) begin
          if (read_pending && $urandom_range(7) != 0) send_read();
          else send_tick();
          ticks++;
        end
        // A long wait would stall later scripts; sometimes skip ahead past it.
        if (wait_until > now_frame + 64'd100 && $urandom_range(1) == 0)
          now_frame = wait_until;
      end
    end

    start <= 1'b0;
    while (status_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d words and checked %0d results (%0d with a failed assert, %0d rejected)",
             words_sent, results_seen, fails_seen, rejects_seen);
    $display("over script runs with waits, presses, polls, asserts, exits and stray words.");
    if (mismatches == 0 && status_queue.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/scrseq_pkg.sv
src/scrseq_store.sv
src/scripted_input_sequencer_top.sv
src/scrseq_checker.sv
test/testbench.sv
